/* design/scoped_linear_probe_symbol_table_macros.svh */
// Assertion helpers shared by the symbol table RTL.
`ifndef SCOPED_LINEAR_PROBE_SYMBOL_TABLE_MACROS_SVH
`define SCOPED_LINEAR_PROBE_SYMBOL_TABLE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SLPST_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SLPST_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* design/slpst_pkg.sv */
package slpst_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 16;
   localparam int VTYPE_W = 4;
   localparam int LIMIT_W = 6;
   localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = 6'd52;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_PUSH   = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4,
      ST_OVERFLOW  = 3'd5,
      ST_UNDERFLOW = 3'd6
   } status_type;

   typedef struct packed {
      logic               used;
      logic [KEY_W-1:0]   key;
      logic [POS_W-1:0]   pos;
      logic [VTYPE_W-1:0] vtype;
   } slot_entry_type;

   typedef struct packed {
      logic hit;
      logic empty;
      logic last;
   } probe_flags_type;

endpackage

/* design/slpst_slot_ram.sv */
module slpst_slot_ram import slpst_pkg::*; #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  slot_entry_type    wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output slot_entry_type    rd_data
);

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/slpst_probe_unit.sv */
module slpst_probe_unit import slpst_pkg::*; #(
   parameter int SLOTS_PER_SCOPE = 64,
   parameter int HASH_SHIFT      = 4
) (
   input  logic [KEY_W-1:0]                   key,
   input  logic [KEY_W-1:0]                   home_key,
   input  slot_entry_type                     entry,
   input  logic [$clog2(SLOTS_PER_SCOPE)-1:0] idx,
   input  logic [$clog2(SLOTS_PER_SCOPE)-1:0] step,
   output logic [$clog2(SLOTS_PER_SCOPE)-1:0] home_idx,
   output logic [$clog2(SLOTS_PER_SCOPE)-1:0] next_idx,
   output probe_flags_type                    flags
);

   localparam int IDX_W = $clog2(SLOTS_PER_SCOPE);

   // table size is a power of two: the low bits of the shifted key are the home slot
   assign home_idx = IDX_W'(home_key >> HASH_SHIFT);
   assign next_idx = IDX_W'(idx + 1'b1);

   assign flags.empty = !entry.used;
   assign flags.hit   = entry.used && (entry.key == key);
   assign flags.last  = (step == IDX_W'(SLOTS_PER_SCOPE - 1));

endmodule

/* design/scoped_linear_probe_symbol_table.sv */
// Scoped symbol table: a stack of MAX_SCOPES open-addressed hash tables of
// SLOTS_PER_SCOPE slots each (a power of two), kept in one single-port-read
// slot RAM and searched by one shared key-compare/index-step unit. An insert
// or lookup probes slots in turn from the key's home slot; a lookup probes the
// innermost scope first and then each outer scope in turn from its home slot.
// Push clears the new scope's slots one a cycle through the RAM write port.
// After reset the block clears all MAX_SCOPES * SLOTS_PER_SCOPE slots with
// req_ready low; csr writes are taken at any time. The block works on one
// request at a time; a finished response waits in the output register while
// the next request is accepted.
module scoped_linear_probe_symbol_table import slpst_pkg::*; #(
   parameter int SLOTS_PER_SCOPE = 64,
   parameter int MAX_SCOPES      = 8,
   parameter int HASH_SHIFT      = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [POS_W-1:0]   req_value_pos,
   input  logic [VTYPE_W-1:0] req_value_type,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [POS_W-1:0]   rsp_found_pos,
   output logic [VTYPE_W-1:0] rsp_found_type,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

`include "scoped_linear_probe_symbol_table_macros.svh"

   localparam int IDX_W   = $clog2(SLOTS_PER_SCOPE);
   localparam int SCOPE_W = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
   localparam int DEPTH   = SLOTS_PER_SCOPE * MAX_SCOPES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(SLOTS_PER_SCOPE + 1);
   localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [SCOPE_W-1:0] s,
                                                   input logic [IDX_W-1:0] i);
      return ADDR_W'({s, i});
   endfunction

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VTYPE_W-1:0] vtype_ff, vtype_in;
   logic [SCOPE_W-1:0] top_ff, top_in;
   logic [SCOPE_W-1:0] scope_ff, scope_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]  clr_end_ff, clr_end_in;
   logic               push_ff, push_in;
   logic [LIMIT_W-1:0] fill_limit_ff, fill_limit_in;
   status_type         res_status_ff, res_status_in;
   logic [POS_W-1:0]   res_pos_ff, res_pos_in;
   logic [VTYPE_W-1:0] res_type_ff, res_type_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [VTYPE_W-1:0] rsp_type_ff, rsp_type_in;
   logic [CNT_W-1:0]   cnt_ff [MAX_SCOPES];

   logic               cnt_we;
   logic [SCOPE_W-1:0] cnt_sel;
   logic [CNT_W-1:0]   cnt_wdata;
   logic [CNT_W-1:0]   cnt_top;
   logic               room;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wr_addr;
   slot_entry_type     ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   slot_entry_type     ram_rd_data;

   logic [KEY_W-1:0]   home_key;
   logic [IDX_W-1:0]   home_idx;
   logic [IDX_W-1:0]   next_idx;
   probe_flags_type    flags;
   logic               accept;
   logic               out_free;

   slpst_slot_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   slpst_probe_unit #(
      .SLOTS_PER_SCOPE (SLOTS_PER_SCOPE),
      .HASH_SHIFT      (HASH_SHIFT)
   ) u_probe (
      .key      (key_ff),
      .home_key (home_key),
      .entry    (ram_rd_data),
      .idx      (idx_ff),
      .step     (step_ff),
      .home_idx (home_idx),
      .next_idx (next_idx),
      .flags    (flags)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign home_key  = (state_ff == S_IDLE) ? req_key : key_ff;
   assign cnt_top   = cnt_ff[top_ff];
   assign room      = (CMP_W'(cnt_top) < CMP_W'(fill_limit_ff)) &&
                      (cnt_top < CNT_W'(SLOTS_PER_SCOPE));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      vtype_in      = vtype_ff;
      top_in        = top_ff;
      scope_in      = scope_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      clr_addr_in   = clr_addr_ff;
      clr_end_in    = clr_end_ff;
      push_in       = push_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_type_in   = res_type_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_type_in   = rsp_type_ff;
      fill_limit_in = csr_wr_en ? csr_wr_data : fill_limit_ff;
      cnt_we        = 1'b0;
      cnt_sel       = top_ff;
      cnt_wdata     = CNT_W'(cnt_top + 1'b1);
      ram_we        = 1'b0;
      ram_wr_addr   = clr_addr_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = slot_addr(scope_ff, idx_ff);

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (clr_addr_ff == clr_end_ff) begin
               state_in = push_ff ? S_DONE : S_IDLE;
            end else begin
               clr_addr_in = ADDR_W'(clr_addr_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in         = op_type'(req_operation);
               key_in        = req_key;
               pos_in        = req_value_pos;
               vtype_in      = req_value_type;
               res_status_in = ST_ADDED;
               res_pos_in    = '0;
               res_type_in   = '0;
               push_in       = 1'b0;
               case (op_type'(req_operation))
                  OP_INSERT, OP_LOOKUP: begin
                     scope_in    = top_ff;
                     idx_in      = home_idx;
                     step_in     = '0;
                     ram_rd_addr = slot_addr(top_ff, home_idx);
                     state_in    = S_PROBE;
                  end
                  OP_PUSH: begin
                     if (top_ff == SCOPE_W'(MAX_SCOPES - 1)) begin
                        res_status_in = ST_OVERFLOW;
                        state_in      = S_DONE;
                     end else begin
                        top_in      = SCOPE_W'(top_ff + 1'b1);
                        cnt_we      = 1'b1;
                        cnt_sel     = SCOPE_W'(top_ff + 1'b1);
                        cnt_wdata   = '0;
                        clr_addr_in = slot_addr(SCOPE_W'(top_ff + 1'b1), '0);
                        clr_end_in  = slot_addr(SCOPE_W'(top_ff + 1'b1), '1);
                        push_in     = 1'b1;
                        state_in    = S_CLEAR;
                     end
                  end
                  default: begin
                     if (top_ff == '0) begin
                        res_status_in = ST_UNDERFLOW;
                     end else begin
                        top_in = SCOPE_W'(top_ff - 1'b1);
                     end
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_PROBE: begin
            if (flags.hit) begin
               if (op_ff == OP_INSERT) begin
                  res_status_in = ST_PRESENT;
               end else begin
                  res_status_in = ST_FOUND;
                  res_pos_in    = ram_rd_data.pos;
                  res_type_in   = ram_rd_data.vtype;
               end
               state_in = S_DONE;
            end else if (op_ff == OP_INSERT) begin
               if (flags.empty && room) begin
                  ram_we            = 1'b1;
                  ram_wr_addr       = slot_addr(top_ff, idx_ff);
                  ram_wr_data.used  = 1'b1;
                  ram_wr_data.key   = key_ff;
                  ram_wr_data.pos   = pos_ff;
                  ram_wr_data.vtype = vtype_ff;
                  cnt_we            = 1'b1;
                  res_status_in     = ST_ADDED;
                  state_in          = S_DONE;
               end else if (flags.empty || flags.last) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  idx_in      = next_idx;
                  step_in     = IDX_W'(step_ff + 1'b1);
                  ram_rd_addr = slot_addr(scope_ff, next_idx);
               end
            end else if (flags.empty || flags.last) begin
               // miss in this scope: go one scope outward or give up
               if (scope_ff == '0) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  scope_in    = SCOPE_W'(scope_ff - 1'b1);
                  idx_in      = home_idx;
                  step_in     = '0;
                  ram_rd_addr = slot_addr(SCOPE_W'(scope_ff - 1'b1), home_idx);
               end
            end else begin
               idx_in      = next_idx;
               step_in     = IDX_W'(step_ff + 1'b1);
               ram_rd_addr = slot_addr(scope_ff, next_idx);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_type_in   = res_type_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         top_ff        <= '0;
         clr_addr_ff   <= '0;
         clr_end_ff    <= ADDR_W'(DEPTH - 1);
         push_ff       <= 1'b0;
         fill_limit_ff <= FILL_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_SCOPES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         clr_addr_ff   <= clr_addr_in;
         clr_end_ff    <= clr_end_in;
         push_ff       <= push_in;
         fill_limit_ff <= fill_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cnt_we) begin
            cnt_ff[cnt_sel] <= cnt_wdata;
         end
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      vtype_ff      <= vtype_in;
      scope_ff      <= scope_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_type_ff   <= res_type_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_type_ff   <= rsp_type_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_pos  = rsp_pos_ff;
   assign rsp_found_type = rsp_type_ff;

   `SLPST_ASSERT_NEXT(a_one_at_a_time, clock, reset, accept, !req_ready,
                      "request accepted while another is in flight")

   `SLPST_ASSERT_IMPLY(a_found_fields, clock, reset,
                       rsp_valid && (rsp_status_ff != ST_FOUND),
                       (rsp_found_pos == '0) && (rsp_found_type == '0),
                       "found fields nonzero on a non-found beat")

   `SLPST_ASSERT_IMPLY(a_insert_write, clock, reset,
                       (state_ff == S_PROBE) && ram_we,
                       (op_ff == OP_INSERT) && (scope_ff == top_ff) && room,
                       "slot write outside the innermost scope or past the fill limit")

endmodule
